// ===== rtl/utf_stream_decoder_assert.svh =====
// assertion macros shared by the decoder rtl
`ifndef UTF_STREAM_DECODER_ASSERT_SVH
`define UTF_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define UTFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UTFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/utfd_pkg.sv =====
package utfd_pkg;

    // format register codes
    localparam logic [2:0] FMT_UTF8    = 3'd0;
    localparam logic [2:0] FMT_UTF16BE = 3'd1;
    localparam logic [2:0] FMT_UTF16LE = 3'd2;
    localparam logic [2:0] FMT_UTF32BE = 3'd3;
    localparam logic [2:0] FMT_UTF32LE = 3'd4;

    typedef logic [2:0]  fmt_t;
    typedef logic [30:0] cp_t;

    // utf-8 lead byte minimum and overlong limits for the second byte
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD_E0_MIN = 8'hA0;
    localparam logic [7:0] LEAD_F0_MIN = 8'h90;
    localparam logic [7:0] LEAD_F8_MIN = 8'h88;
    localparam logic [7:0] LEAD_FC_MIN = 8'h84;

    // surrogate bounds, supplementary base and code point limit
    localparam logic [15:0] SURR_HIGH = 16'hD800;
    localparam logic [15:0] SURR_LOW  = 16'hDC00;
    localparam logic [15:0] SURR_END  = 16'hE000;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [23:0] CP_LIMIT  = 24'h110000;

endpackage

// ===== rtl/utf_stream_decoder.sv =====
// Byte-serial Unicode decoder: takes one byte per cycle and returns one request per completed
// code point (UTF-8 incl. 5/6-byte forms, UTF-16 BE/LE, UTF-32 BE/LE, chosen by the format register).
// A registered result shows in the cycle after the byte that completes it; the per-byte update
// is a single pass of logic into the sequence state and the result register, so a new byte is
// taken every cycle. The one-entry result register holds a result while the output is stalled,
// and input is stalled only in cycles where that register is full and its consumer stalls.
// Malformed sequences give invalid = 1 with code_point = 0, and the decoder returns to idle.
// Writing the format register drops any partial sequence; write it only while the decoder is idle.
module utf_stream_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  utfd_pkg::fmt_t       cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           byte_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output utfd_pkg::cp_t        code_point,
    output logic                 invalid
);
    import utfd_pkg::*;

    fmt_t        fmt_reg;
    logic [30:0] acc_reg, acc_next;
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  lead_reg, lead_next;
    logic        bad_reg, bad_next;
    logic [15:0] hs_reg, hs_next;

    logic        out_valid_reg;
    logic [30:0] cp_reg;
    logic        inv_reg;

    logic        in_fire;
    logic        emit;
    logic [30:0] emit_cp;
    logic        emit_bad;

    logic        bad8;
    logic [15:0] unit;
    logic [2:0]  pos32;
    logic        bad32;
    logic [20:0] pair_cp;

    assign in_stall   = out_valid_reg & out_stall;
    assign in_fire    = in_valid & ~in_stall;
    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign invalid    = inv_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        lead_next = lead_reg;
        bad_next  = bad_reg;
        hs_next   = hs_reg;
        emit      = 1'b0;
        emit_cp   = '0;
        emit_bad  = 1'b0;

        // utf-8 continuation fault: an earlier fault, wrong marker bits or overlong second byte
        bad8 = bad_reg | (byte_in[7:6] != 2'b10) |
               ((pos_reg == 3'd1) &&
                ((lead_reg == 8'hE0 && byte_in < LEAD_E0_MIN) ||
                 (lead_reg == 8'hF0 && byte_in < LEAD_F0_MIN) ||
                 (lead_reg == 8'hF8 && byte_in < LEAD_F8_MIN) ||
                 (lead_reg == 8'hFC && byte_in < LEAD_FC_MIN)));

        unit = (fmt_reg == FMT_UTF16BE) ? {lead_reg, byte_in} : {byte_in, lead_reg};
        pair_cp = SUPP_BASE + {1'b0, hs_reg[9:0], unit[9:0]};

        pos32 = (rem_reg == 3'd0) ? 3'd0 : pos_reg;
        bad32 = 1'b0;

        unique case (fmt_reg) inside
            FMT_UTF8:
            begin
                if (rem_reg == 3'd0)
                begin
                    if (!byte_in[7])
                    begin
                        emit    = 1'b1;
                        emit_cp = {23'd0, byte_in};
                    end
                    else if (byte_in < LEAD_MIN || byte_in >= 8'hFE)
                    begin
                        emit     = 1'b1;
                        emit_bad = 1'b1;
                    end
                    else
                    begin
                        lead_next = byte_in;
                        bad_next  = 1'b0;
                        pos_next  = 3'd1;
                        if (byte_in < 8'hE0)
                        begin
                            rem_next = 3'd1;
                            acc_next = {26'd0, byte_in[4:0]};
                        end
                        else if (byte_in < 8'hF0)
                        begin
                            rem_next = 3'd2;
                            acc_next = {27'd0, byte_in[3:0]};
                        end
                        else if (byte_in < 8'hF8)
                        begin
                            rem_next = 3'd3;
                            acc_next = {28'd0, byte_in[2:0]};
                        end
                        else if (byte_in < 8'hFC)
                        begin
                            rem_next = 3'd4;
                            acc_next = {29'd0, byte_in[1:0]};
                        end
                        else
                        begin
                            rem_next = 3'd5;
                            acc_next = {30'd0, byte_in[0]};
                        end
                    end
                end
                else
                begin
                    acc_next = {acc_reg[24:0], byte_in[5:0]};
                    bad_next = bad8;
                    rem_next = rem_reg - 3'd1;
                    pos_next = pos_reg + 3'd1;
                    if (rem_reg == 3'd1)
                    begin
                        emit     = 1'b1;
                        emit_bad = bad8;
                        emit_cp  = {acc_reg[24:0], byte_in[5:0]};
                    end
                end
            end

            FMT_UTF16BE, FMT_UTF16LE:
            begin
                if (rem_reg == 3'd0 || pos_reg == 3'd2)
                begin
                    // first byte of a unit
                    lead_next = byte_in;
                    rem_next  = 3'd1;
                    if (rem_reg == 3'd0)
                    begin
                        hs_next  = '0;
                        pos_next = 3'd1;
                    end
                    else
                    begin
                        pos_next = 3'd3;
                    end
                end
                else if (pos_reg == 3'd1)
                begin
                    if (unit >= SURR_HIGH && unit < SURR_LOW)
                    begin
                        hs_next  = unit;
                        rem_next = 3'd2;
                        pos_next = 3'd2;
                    end
                    else if (unit >= SURR_LOW && unit < SURR_END)
                    begin
                        emit     = 1'b1;
                        emit_bad = 1'b1;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        emit_cp = {15'd0, unit};
                    end
                end
                else
                begin
                    // second unit of a pair must be a low surrogate
                    emit = 1'b1;
                    if (unit >= SURR_LOW && unit < SURR_END)
                        emit_cp = {10'd0, pair_cp};
                    else
                        emit_bad = 1'b1;
                end
            end

            FMT_UTF32BE, FMT_UTF32LE:
            begin
                bad32 = bad_reg;
                if (fmt_reg == FMT_UTF32BE)
                begin
                    if (pos32 == 3'd0)
                    begin
                        acc_next = '0;
                        bad32    = (byte_in != 8'd0);
                    end
                    else
                    begin
                        acc_next = {7'd0, acc_reg[15:0], byte_in};
                    end
                end
                else
                begin
                    if (pos32 == 3'd0)
                    begin
                        acc_next = {23'd0, byte_in};
                        bad32    = 1'b0;
                    end
                    else if (pos32 == 3'd1)
                        acc_next = acc_reg | {15'd0, byte_in, 8'd0};
                    else if (pos32 == 3'd2)
                        acc_next = acc_reg | {7'd0, byte_in, 16'd0};
                    else if (byte_in != 8'd0)
                        bad32 = 1'b1;
                end
                bad_next = bad32;
                if (pos32 == 3'd3)
                begin
                    emit     = 1'b1;
                    emit_bad = bad32 || acc_next[23:0] >= CP_LIMIT ||
                               (acc_next[23:0] >= {8'd0, SURR_HIGH} &&
                                acc_next[23:0] < {8'd0, SURR_END});
                    emit_cp  = acc_next;
                end
                else
                begin
                    pos_next = pos32 + 3'd1;
                    rem_next = 3'd3 - pos32;
                end
            end

            default:
            begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
        endcase

        if (emit)
        begin
            acc_next  = '0;
            rem_next  = '0;
            pos_next  = '0;
            lead_next = '0;
            bad_next  = 1'b0;
            hs_next   = '0;
            if (emit_bad)
                emit_cp = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_UTF8;
            acc_reg  <= '0;
            rem_reg  <= '0;
            pos_reg  <= '0;
            lead_reg <= '0;
            bad_reg  <= 1'b0;
            hs_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            // format change drops the partial sequence
            fmt_reg  <= cfg_wr_data;
            acc_reg  <= '0;
            rem_reg  <= '0;
            pos_reg  <= '0;
            lead_reg <= '0;
            bad_reg  <= 1'b0;
            hs_reg   <= '0;
        end
        else if (in_fire)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            pos_reg  <= pos_next;
            lead_reg <= lead_next;
            bad_reg  <= bad_next;
            hs_reg   <= hs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            cp_reg  <= emit_cp;
            inv_reg <= emit_bad;
        end
    end

    `include "utf_stream_decoder_assert.svh"

    `UTFD_ASSERT_NOW(a_invalid_zero, out_valid_reg && inv_reg, cp_reg == '0, "invalid result with nonzero code point")
    `UTFD_ASSERT_NOW(a_idle_pos_zero, rem_reg == 3'd0, pos_reg == 3'd0 && bad_reg == 1'b0, "idle decoder holds sequence position")
    `UTFD_ASSERT_NOW(a_rem_range, 1'b1, rem_reg != 3'd6 && rem_reg != 3'd7, "bytes remaining out of range")
    `UTFD_ASSERT_NEXT(a_out_drain, out_valid_reg && !out_stall && !(in_fire && emit), !out_valid_reg, "delivered result not retired")

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utfd_pkg::*;

    localparam int   CYCLE_LIMIT   = 300000;
    localparam int   DRAIN_CYCLES  = 4;
    localparam int   HOLD_CYCLES   = 60;
    localparam int   BYTES_PER_RUN = 52;
    localparam fmt_t FMT_UNUSED_LO = 3'd5;
    localparam fmt_t FMT_UNUSED_HI = 3'd7;

    typedef struct {
        cp_t  cp;
        logic bad;
    } decoded_t;

    typedef logic [7:0] byte_q_t[$];

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    fmt_t       cfg_wr_data = FMT_UTF8;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in     = 8'h00;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    cp_t        code_point;
    logic       invalid;

    utf_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .invalid    (invalid)
    );

    always #2 clk = ~clk;

    // decoder state as seen by the predictor
    fmt_t        cur_fmt = FMT_UTF8;
    logic [30:0] acc;
    logic [2:0]  remaining;
    logic [2:0]  position;
    logic [7:0]  lead;
    logic        seq_bad;
    logic [15:0] hi_unit;

    decoded_t    expected_points[$];
    int          mismatches        = 0;
    int          bytes_sent        = 0;
    int          cycles            = 0;
    int          sender_idle_pct   = 35;
    int          receiver_idle_pct = 75;
    logic        holding           = 1'b0;
    event        hold_ev;

    function automatic void clear_decoder();
        acc       = '0;
        remaining = '0;
        position  = '0;
        lead      = '0;
        seq_bad   = 1'b0;
        hi_unit   = '0;
    endfunction

    // returns 1 when this byte completes a sequence
    function automatic bit decode_byte(input logic [7:0] b, output cp_t cp, output logic bad);
        bit          done;
        logic        fault;
        cp_t         val;
        logic [15:0] word16;
        logic [2:0]  pos;
        logic        big;
        done  = 1'b0;
        fault = 1'b0;
        val   = '0;
        cp    = '0;
        bad   = 1'b0;
        case (cur_fmt) inside
            FMT_UTF8:
            begin
                if (remaining == 0)
                begin
                    if (b < 8'h80)
                    begin
                        done = 1'b1;
                        val  = cp_t'(b);
                    end
                    else if (b < LEAD_MIN || b >= 8'hFE)
                    begin
                        done  = 1'b1;
                        fault = 1'b1;
                    end
                    else
                    begin
                        lead     = b;
                        seq_bad  = 1'b0;
                        position = 3'd1;
                        if (b < 8'hE0)
                        begin
                            remaining = 3'd1;
                            acc       = cp_t'(b[4:0]);
                        end
                        else if (b < 8'hF0)
                        begin
                            remaining = 3'd2;
                            acc       = cp_t'(b[3:0]);
                        end
                        else if (b < 8'hF8)
                        begin
                            remaining = 3'd3;
                            acc       = cp_t'(b[2:0]);
                        end
                        else if (b < 8'hFC)
                        begin
                            remaining = 3'd4;
                            acc       = cp_t'(b[1:0]);
                        end
                        else
                        begin
                            remaining = 3'd5;
                            acc       = cp_t'(b[0]);
                        end
                    end
                end
                else
                begin
                    if (b[7:6] != 2'b10)
                        seq_bad = 1'b1;
                    // overlong forms are caught on the second byte
                    if (position == 1 &&
                        ((lead == 8'hE0 && b < LEAD_E0_MIN) ||
                         (lead == 8'hF0 && b < LEAD_F0_MIN) ||
                         (lead == 8'hF8 && b < LEAD_F8_MIN) ||
                         (lead == 8'hFC && b < LEAD_FC_MIN)))
                        seq_bad = 1'b1;
                    acc       = {acc[24:0], b[5:0]};
                    remaining = remaining - 3'd1;
                    position  = position + 3'd1;
                    if (remaining == 0)
                    begin
                        done  = 1'b1;
                        val   = acc;
                        fault = seq_bad;
                    end
                end
            end
            FMT_UTF16BE, FMT_UTF16LE:
            begin
                big = (cur_fmt == FMT_UTF16BE);
                if (remaining == 0 || position == 2)
                begin
                    if (remaining == 0)
                    begin
                        hi_unit  = '0;
                        position = '0;
                    end
                    lead      = b;
                    remaining = 3'd1;
                    position  = position + 3'd1;
                end
                else
                begin
                    word16 = big ? {lead, b} : {b, lead};
                    if (position == 1)
                    begin
                        if (word16 >= SURR_HIGH && word16 < SURR_LOW)
                        begin
                            hi_unit   = word16;
                            remaining = 3'd2;
                            position  = 3'd2;
                        end
                        else if (word16 >= SURR_LOW && word16 < SURR_END)
                        begin
                            done  = 1'b1;
                            fault = 1'b1;
                        end
                        else
                        begin
                            done = 1'b1;
                            val  = cp_t'(word16);
                        end
                    end
                    else if (word16 >= SURR_LOW && word16 < SURR_END)
                    begin
                        done = 1'b1;
                        val  = cp_t'(SUPP_BASE) + (cp_t'(hi_unit - SURR_HIGH) << 10) +
                               cp_t'(word16 - SURR_LOW);
                    end
                    else
                    begin
                        done  = 1'b1;
                        fault = 1'b1;
                    end
                end
            end
            FMT_UTF32BE, FMT_UTF32LE:
            begin
                pos = (remaining == 0) ? 3'd0 : position;
                if (cur_fmt == FMT_UTF32BE)
                begin
                    if (pos == 0)
                    begin
                        acc     = '0;
                        seq_bad = (b != 0);
                    end
                    else
                        acc = {7'd0, acc[15:0], b};
                end
                else
                begin
                    if (pos == 0)
                    begin
                        acc     = cp_t'(b);
                        seq_bad = 1'b0;
                    end
                    else if (pos < 3)
                        acc = acc | (cp_t'(b) << (8 * pos));
                    else if (b != 0)
                        seq_bad = 1'b1;
                end
                if (pos == 3)
                begin
                    done  = 1'b1;
                    val   = acc;
                    fault = seq_bad || acc >= CP_LIMIT ||
                            (acc >= SURR_HIGH && acc < SURR_END);
                end
                else
                begin
                    position  = pos + 3'd1;
                    remaining = 3'd3 - pos;
                end
            end
            default:
            begin
                done  = 1'b1;
                fault = 1'b1;
            end
        endcase
        if (done)
        begin
            cp  = fault ? '0 : val;
            bad = fault;
            clear_decoder();
        end
        return done;
    endfunction

    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < receiver_idle_pct);

    // long receiver hold-off, counted here
    always
    begin
        @(hold_ev);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected request: code_point %h invalid %b", code_point, invalid);
                mismatches++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (code_point !== want.cp)
                begin
                    $error("code_point: expected %h, actual %h", want.cp, code_point);
                    mismatches++;
                end
                if (invalid !== want.bad)
                begin
                    $error("invalid: expected %b, actual %b", want.bad, invalid);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $error("timeout with %0d results outstanding", expected_points.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        cp_t  cp;
        logic bad;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        if (decode_byte(b, cp, bad))
            expected_points.push_back('{cp, bad});
    endtask

    task automatic send_seq(input byte_q_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // sender pauses until every expected request has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_format(input fmt_t f);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= f;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_fmt = f;
        clear_decoder();
    endtask

    task automatic send_utf8_char();
        byte_q_t    seq;
        int         len;
        int         pick;
        logic [7:0] min2;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        len  = pick < 30 ? 1 : pick < 50 ? 2 : pick < 70 ? 3 : pick < 85 ? 4 : pick < 93 ? 5 : 6;
        case (len)
            1: seq.push_back(8'($urandom_range(8'h7F)));
            2: seq.push_back(8'($urandom_range(8'hDF, LEAD_MIN)));
            3: seq.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            4: seq.push_back(8'($urandom_range(8'hF7, 8'hF0)));
            5: seq.push_back(8'($urandom_range(8'hFB, 8'hF8)));
            default: seq.push_back(8'($urandom_range(8'hFD, 8'hFC)));
        endcase
        // the lowest lead of each length from three bytes up carries the overlong check
        if (len >= 3 && $urandom_range(3) == 0)
            seq[0] = len == 3 ? 8'hE0 : len == 4 ? 8'hF0 : len == 5 ? 8'hF8 : 8'hFC;
        case (seq[0])
            8'hE0:   min2 = LEAD_E0_MIN;
            8'hF0:   min2 = LEAD_F0_MIN;
            8'hF8:   min2 = LEAD_F8_MIN;
            8'hFC:   min2 = LEAD_FC_MIN;
            default: min2 = 8'h80;
        endcase
        for (int i = 1; i < len; i++)
            seq.push_back(8'($urandom_range(8'hBF, i == 1 ? min2 : 8'h80)));
        if (len > 1 && $urandom_range(99) < 15)
        begin
            if (min2 != 8'h80 && $urandom_range(1) == 1)
                seq[1] = 8'($urandom_range(min2 - 8'd1, 8'h80));
            else
                seq[$urandom_range(len - 1, 1)] = 8'($urandom_range(255));
        end
        send_seq(seq);
    endtask

    task automatic send_utf16_unit(input logic [15:0] u, input logic big);
        if (big)
        begin
            send_byte(u[15:8]);
            send_byte(u[7:0]);
        end
        else
        begin
            send_byte(u[7:0]);
            send_byte(u[15:8]);
        end
    endtask

    task automatic send_utf16_char(input logic big);
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            send_byte(8'($urandom_range(255)));
        else if (pick < 55)
            send_utf16_unit($urandom_range(1) == 1 ? 16'($urandom_range(16'hD7FF)) :
                            16'($urandom_range(16'hFFFF, SURR_END)), big);
        else if (pick < 85)
        begin
            send_utf16_unit(16'($urandom_range(SURR_LOW - 16'd1, SURR_HIGH)), big);
            send_utf16_unit(16'($urandom_range(SURR_END - 16'd1, SURR_LOW)), big);
        end
        else if (pick < 92)
            send_utf16_unit(16'($urandom_range(SURR_END - 16'd1, SURR_LOW)), big);
        else
        begin
            // high unit followed by anything
            send_utf16_unit(16'($urandom_range(SURR_LOW - 16'd1, SURR_HIGH)), big);
            send_utf16_unit(16'($urandom_range(16'hFFFF)), big);
        end
    endtask

    task automatic send_utf32_char(input logic big);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            send_byte(8'($urandom_range(255)));
            return;
        end
        if (pick < 55)
        begin
            v = $urandom_range(32'h10FFFF);
            if (v >= SURR_HIGH && v < SURR_END)
                v = v ^ 32'h8000;
        end
        else if (pick < 65)
        begin
            case ($urandom_range(5))
                0:       v = 32'h0;
                1:       v = 32'h10FFFF;
                2:       v = 32'hD7FF;
                3:       v = 32'hE000;
                4:       v = 32'hD800;
                default: v = 32'h110000;
            endcase
        end
        else if (pick < 75)
            v = $urandom_range(32'hDFFF, 32'hD800);
        else if (pick < 88)
            v = $urandom_range(32'hFFFFFF, 32'h110000);
        else
            v = $urandom();
        if (big)
            send_seq({v[31:24], v[23:16], v[15:8], v[7:0]});
        else
            send_seq({v[7:0], v[15:8], v[23:16], v[31:24]});
    endtask

    // format after reset is utf-8, so no write here
    task automatic test_utf8_edges();
        send_seq({8'h00, 8'h7F, 8'h80, 8'hC1, 8'hFE, 8'hFF});
        send_seq({8'hDF, 8'hBF});
        // overlong three-byte form
        send_seq({8'hE0, 8'h9F, 8'h80});
        // largest six-byte value
        send_seq({8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
    endtask

    task automatic test_utf16_pairs();
        set_format(FMT_UTF16BE);
        send_seq({8'hD8, 8'h00, 8'hDC, 8'h00});
        set_format(FMT_UTF16LE);
        // lone low unit, then an unpaired high unit
        send_seq({8'h00, 8'hDC});
        send_seq({8'hFF, 8'hDB, 8'h41, 8'h00});
    endtask

    task automatic test_utf32_range();
        set_format(FMT_UTF32LE);
        send_seq({8'hFF, 8'hFF, 8'h10, 8'h00});
        set_format(FMT_UTF32BE);
        send_seq({8'h00, 8'h11, 8'h00, 8'h00});
    endtask

    task automatic test_unused_formats();
        set_format(FMT_UNUSED_HI);
        send_seq({8'hA5, 8'h5A});
        set_format(FMT_UNUSED_LO);
        send_byte(8'h00);
    endtask

    task automatic test_random_streams();
        int start;
        for (int mode = 0; mode < 3; mode++)
        begin
            sender_idle_pct   = mode == 0 ? 35 : mode == 1 ? 75 : 0;
            receiver_idle_pct = mode == 0 ? 75 : mode == 1 ? 35 : 0;
            for (int f = FMT_UTF8; f <= FMT_UTF32LE; f++)
            begin
                set_format(fmt_t'(f));
                start = bytes_sent;
                while (bytes_sent - start < BYTES_PER_RUN)
                begin
                    case (fmt_t'(f))
                        FMT_UTF8:    send_utf8_char();
                        FMT_UTF16BE: send_utf16_char(1'b1);
                        FMT_UTF16LE: send_utf16_char(1'b0);
                        FMT_UTF32BE: send_utf32_char(1'b1);
                        default:     send_utf32_char(1'b0);
                    endcase
                end
            end
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_format(FMT_UTF8);
        // receiver holds off while the sender keeps offering
        -> hold_ev;
        repeat (30) send_utf8_char();
        wait_idle();
        receiver_idle_pct = 50;
        repeat (20) send_utf8_char();
    endtask

    initial
    begin
        clear_decoder();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_utf8_edges();
        test_utf16_pairs();
        test_utf32_range();
        test_unused_formats();
        test_random_streams();
        test_backpressure();
        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
